// ----- rtl/hfde_pkg.sv -----
// ----------------------------------------------------------------------------
// hfde_pkg
// Shared types and codes of the hierarchical state machine dispatch engine.
// ----------------------------------------------------------------------------
package hfde_pkg;

    localparam logic [6:0] NO_STATE = 7'd64;

    // input item modes
    localparam logic [1:0] MODE_DISPATCH = 2'd0;
    localparam logic [1:0] MODE_WR_STATE = 2'd1;
    localparam logic [1:0] MODE_WR_TRANS = 2'd2;
    localparam logic [1:0] MODE_RESTART  = 2'd3;

    // result kinds
    localparam logic [1:0] KIND_EXIT   = 2'd0;
    localparam logic [1:0] KIND_TRANS  = 2'd1;
    localparam logic [1:0] KIND_ENTRY  = 2'd2;
    localparam logic [1:0] KIND_STATUS = 2'd3;

    // status codes
    localparam logic [2:0] STAT_CHANGED  = 3'd0;
    localparam logic [2:0] STAT_SELF     = 3'd1;
    localparam logic [2:0] STAT_NOCHANGE = 3'd2;
    localparam logic [2:0] STAT_ERROR    = 3'd3;
    localparam logic [2:0] STAT_FINAL    = 3'd4;
    localparam logic [2:0] STAT_ACCEPTED = 3'd5;

    // config register indexes
    localparam int         CFG_IDX_W = 1;
    localparam logic [0:0] CFG_INITIAL = 1'd0;
    localparam logic [0:0] CFG_ERROR   = 1'd1;

    typedef struct packed {
        logic [6:0] parent;
        logic [6:0] entry;
        logic [7:0] first;
        logic [4:0] count;
        logic [1:0] flags;
    } t_st_ent;

    typedef struct packed {
        logic [7:0] ev;
        logic [6:0] next;
        logic [4:0] guard;
        logic       act;
    } t_tr_ent;

    typedef struct packed {
        logic [1:0] kind;
        logic [6:0] subj;
        logic [6:0] oth;
        logic [2:0] stat;
        logic       last;
    } t_res;

    function automatic t_res mk_res(input logic [1:0] kind, input logic [6:0] subj,
                                    input logic [6:0] oth, input logic [2:0] stat);
        t_res r;
        r.kind = kind;
        r.subj = subj;
        r.oth  = oth;
        r.stat = stat;
        r.last = (kind == KIND_STATUS);
        return r;
    endfunction

endpackage

// ----- rtl/hfde_in_if.sv -----
// ----------------------------------------------------------------------------
// hfde_in_if
// Request channel: valid/ready plus one input item.
// ----------------------------------------------------------------------------
interface hfde_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [7:0]  index;
    logic [7:0]  event_type;
    logic [15:0] guard_bits;
    logic [6:0]  link_a;
    logic [6:0]  link_b;
    logic [7:0]  first_slot;
    logic [4:0]  slot_count;
    logic [4:0]  guard_number;
    logic [1:0]  action_flags;

    modport source (output valid, mode, index, event_type, guard_bits, link_a, link_b,
                    first_slot, slot_count, guard_number, action_flags, input ready);
    modport sink (input valid, mode, index, event_type, guard_bits, link_a, link_b,
                  first_slot, slot_count, guard_number, action_flags, output ready);
endinterface

// ----- rtl/hfde_out_if.sv -----
// ----------------------------------------------------------------------------
// hfde_out_if
// Result channel: valid/ready plus one result item.
// ----------------------------------------------------------------------------
interface hfde_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [6:0] subject_state;
    logic [6:0] other_state;
    logic [2:0] status;
    logic       last;

    modport source (output valid, kind, subject_state, other_state, status, last,
                    input ready);
    modport sink (input valid, kind, subject_state, other_state, status, last,
                  output ready);
endinterface

// ----- rtl/hfde_ram.sv -----
// ----------------------------------------------------------------------------
// hfde_ram
// Generic RAM, one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module hfde_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- rtl/hierarchical_fsm_dispatch_engine.sv -----
// ----------------------------------------------------------------------------
// hierarchical_fsm_dispatch_engine
// Table-driven hierarchical state machine with event dispatch.
//
// State and transition tables live in RAM and are loaded by write beats
// (mode 1 and 2); restart (mode 3) and table writes take one beat in and
// answer with one status beat. A dispatch (mode 0) is run by a single
// sequencer against the state RAM, the transition RAM and a small scratch
// RAM holding the two ancestor paths; most steps are a registered RAM read
// followed by a check state. A dispatch searches the levels and scans
// their slots, descends through entry substates, builds both paths,
// compares the shared ancestors, visits path states for exit and entry
// actions and emits the result beats. One item is in flight at a
// time; the output register lets the next item be taken while the final
// status beat still waits downstream. Config writes are only legal while
// idle. Table entries are undefined until written.
// ----------------------------------------------------------------------------
module hierarchical_fsm_dispatch_engine
    import hfde_pkg::*;
#(
    parameter int NUM_STATES    = 64,
    parameter int NUM_SLOTS     = 256,
    parameter int MAX_DEPTH     = 8,
    parameter int MAX_PER_STATE = 16,
    parameter int NUM_GUARDS    = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [6:0]           i_cfg_data,
    hfde_in_if.sink              i_req,
    hfde_out_if.source           o_rsp
);
    localparam int SAW = $clog2(NUM_STATES);
    localparam int TAW = $clog2(NUM_SLOTS);
    localparam int LW  = $clog2(MAX_DEPTH + 1);
    localparam int PAW = $clog2(2 * MAX_DEPTH);

    typedef enum logic [27:0] {
        S_IDLE     = 28'h0000001,
        S_EMIT     = 28'h0000002,
        S_ERR_A    = 28'h0000004,
        S_ERR_B    = 28'h0000008,
        S_ERR_C    = 28'h0000010,
        S_SRCH_RD  = 28'h0000020,
        S_SRCH_ST  = 28'h0000040,
        S_SCAN_RD  = 28'h0000080,
        S_SCAN_CHK = 28'h0000100,
        S_FOUND    = 28'h0000200,
        S_DESC_RD  = 28'h0000400,
        S_DESC_CHK = 28'h0000800,
        S_CP_RD    = 28'h0001000,
        S_CP_CHK   = 28'h0002000,
        S_TP_RD    = 28'h0004000,
        S_TP_CHK   = 28'h0008000,
        S_CMP_A    = 28'h0010000,
        S_CMP_B    = 28'h0020000,
        S_CMP_C    = 28'h0040000,
        S_EX_A     = 28'h0080000,
        S_EX_B     = 28'h0100000,
        S_EX_C     = 28'h0200000,
        S_TR       = 28'h0400000,
        S_EN_A     = 28'h0800000,
        S_EN_B     = 28'h1000000,
        S_EN_C     = 28'h2000000,
        S_ST_RD    = 28'h4000000,
        S_ST_C     = 28'h8000000
    } t_state;

    // a 7-bit value names a state only below NUM_STATES and below 64
    function automatic logic [6:0] norm(input logic [6:0] v);
        return (int'(v) < NUM_STATES && v < 7'd64) ? v : NO_STATE;
    endfunction

    function automatic logic [SAW-1:0] st_addr(input logic [6:0] s);
        return SAW'(s);
    endfunction

    // first slot modulo NUM_SLOTS, restoring remainder over eight steps
    function automatic logic [TAW-1:0] slot_mod(input logic [7:0] v);
        int r;
        r = int'(v);
        for (int b = 7; b >= 0; b--) begin
            if (r >= (NUM_SLOTS << b)) begin
                r = r - (NUM_SLOTS << b);
            end
        end
        return TAW'(r);
    endfunction

    function automatic logic guard_ok(input t_tr_ent t, input logic [15:0] g);
        if (int'(t.guard) >= NUM_GUARDS) begin
            return 1'b1;
        end else if (t.guard[4]) begin
            return 1'b0;
        end
        return g[t.guard[3:0]];
    endfunction

    t_state          r_state;
    t_state          r_ret;
    logic [6:0]      r_cur, r_prev, r_init, r_err;
    logic            r_ov;
    t_res            r_out, r_res;
    logic [7:0]      r_ev;
    logic [15:0]     r_gbits;
    logic [6:0]      r_s, r_parent, r_leaf, r_c;
    logic            r_act;
    logic [LW-1:0]   r_lvl, r_d, r_cd, r_ci, r_tj, r_pk;
    logic [4:0]      r_k, r_cnt;
    logic [TAW-1:0]  r_slot;

    // RAM ports
    logic            st_we;
    logic [SAW-1:0]  st_raddr;
    t_st_ent         st_wdata, st_q;
    logic            tr_we;
    t_tr_ent         tr_wdata, tr_q;
    logic            p_we;
    logic [PAW-1:0]  p_waddr, p_raddr;
    logic [6:0]      p_q;

    logic            acc, out_free;
    logic [6:0]      p_par, p_ent;
    logic [4:0]      cnt_clip;

    assign acc      = (r_state == S_IDLE) && i_req.valid;
    assign out_free = !r_ov || o_rsp.ready;
    assign i_req.ready = (r_state == S_IDLE);

    assign st_we    = acc && (i_req.mode == MODE_WR_STATE) && (int'(i_req.index) < NUM_STATES);
    assign tr_we    = acc && (i_req.mode == MODE_WR_TRANS) && (int'(i_req.index) < NUM_SLOTS);
    assign st_wdata = '{parent: i_req.link_a, entry: i_req.link_b, first: i_req.first_slot,
                        count: i_req.slot_count, flags: i_req.action_flags};
    assign tr_wdata = '{ev: i_req.event_type, next: i_req.link_a, guard: i_req.guard_number,
                        act: i_req.action_flags[0]};

    assign p_par = norm(st_q.parent);
    assign p_ent = norm(st_q.entry);

    always_comb begin
        cnt_clip = st_q.count;
        if (int'(st_q.count) > MAX_PER_STATE) begin
            cnt_clip = 5'(MAX_PER_STATE);
        end
    end

    // read address and path write selection per sequencer step
    always_comb begin
        st_raddr = '0;
        p_we     = 1'b0;
        p_waddr  = '0;
        p_raddr  = '0;
        case (r_state)
            S_ERR_A:   st_raddr = st_addr(r_err);
            S_SRCH_RD: st_raddr = st_addr(r_s);
            S_DESC_RD: st_raddr = st_addr(r_leaf);
            S_ST_RD:   st_raddr = st_addr(r_leaf);
            S_CP_RD: begin
                st_raddr = st_addr(r_s);
                p_we     = 1'b1;
                p_waddr  = PAW'(r_d);
            end
            S_TP_RD: begin
                st_raddr = st_addr(r_s);
                p_we     = 1'b1;
                p_waddr  = PAW'(MAX_DEPTH + int'(r_d));
            end
            S_CMP_A:   p_raddr = PAW'(int'(r_ci) - 1);
            S_CMP_B:   p_raddr = PAW'(MAX_DEPTH + int'(r_tj) - 1);
            S_EX_A:    p_raddr = PAW'(r_pk);
            S_EN_A:    p_raddr = PAW'(MAX_DEPTH + int'(r_pk) - 1);
            S_EX_B:    st_raddr = st_addr(p_q);
            S_EN_B:    st_raddr = st_addr(p_q);
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= S_IDLE;
            r_cur   <= NO_STATE;
            r_prev  <= NO_STATE;
            r_init  <= 7'd0;
            r_err   <= NO_STATE;
            r_ov    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_INITIAL) begin
                    r_init <= norm(i_cfg_data);
                end else begin
                    r_err <= norm(i_cfg_data);
                end
            end

            // S_EMIT reloads the output register itself
            if (r_ov && o_rsp.ready && r_state != S_EMIT) begin
                r_ov <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_ev    <= i_req.event_type;
                        r_gbits <= i_req.guard_bits;
                        r_ret   <= S_IDLE;
                        case (i_req.mode)
                            MODE_DISPATCH: begin
                                r_s   <= r_cur;
                                r_lvl <= '0;
                                r_state <= (r_cur == NO_STATE) ? S_ERR_A : S_SRCH_RD;
                            end
                            MODE_RESTART: begin
                                r_cur   <= r_init;
                                r_prev  <= NO_STATE;
                                r_res   <= mk_res(KIND_STATUS, r_init, NO_STATE, STAT_ACCEPTED);
                                r_state <= S_EMIT;
                            end
                            default: begin
                                r_res   <= mk_res(KIND_STATUS, r_cur, r_prev, STAT_ACCEPTED);
                                r_state <= S_EMIT;
                            end
                        endcase
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_ov    <= 1'b1;
                        r_out   <= r_res;
                        r_state <= r_ret;
                    end
                end
                // error entry
                S_ERR_A: begin
                    r_prev <= r_cur;
                    r_cur  <= r_err;
                    if (r_err != NO_STATE) begin
                        r_state <= S_ERR_B;
                    end else begin
                        r_res   <= mk_res(KIND_STATUS, r_err, r_cur, STAT_ERROR);
                        r_ret   <= S_IDLE;
                        r_state <= S_EMIT;
                    end
                end
                S_ERR_B: begin
                    if (st_q.flags[0]) begin
                        r_res   <= mk_res(KIND_ENTRY, r_cur, NO_STATE, STAT_CHANGED);
                        r_ret   <= S_ERR_C;
                        r_state <= S_EMIT;
                    end else begin
                        r_state <= S_ERR_C;
                    end
                end
                S_ERR_C: begin
                    r_res   <= mk_res(KIND_STATUS, r_cur, r_prev, STAT_ERROR);
                    r_ret   <= S_IDLE;
                    r_state <= S_EMIT;
                end
                // transition search, innermost state first
                S_SRCH_RD: r_state <= S_SRCH_ST;
                S_SRCH_ST: begin
                    r_parent <= p_par;
                    r_slot   <= slot_mod(st_q.first);
                    r_k      <= '0;
                    r_cnt    <= cnt_clip;
                    if (cnt_clip != 5'd0) begin
                        r_state <= S_SCAN_RD;
                    end else if (int'(r_lvl) + 1 >= MAX_DEPTH || p_par == NO_STATE) begin
                        r_res   <= mk_res(KIND_STATUS, r_cur, r_prev, STAT_NOCHANGE);
                        r_ret   <= S_IDLE;
                        r_state <= S_EMIT;
                    end else begin
                        r_s     <= p_par;
                        r_lvl   <= r_lvl + LW'(1);
                        r_state <= S_SRCH_RD;
                    end
                end
                S_SCAN_RD: r_state <= S_SCAN_CHK;
                S_SCAN_CHK: begin
                    if (tr_q.ev == r_ev && guard_ok(tr_q, r_gbits)) begin
                        r_leaf  <= norm(tr_q.next);
                        r_act   <= tr_q.act;
                        r_state <= S_FOUND;
                    end else if (r_k + 5'd1 != r_cnt) begin
                        r_k     <= r_k + 5'd1;
                        r_slot  <= (r_slot == TAW'(NUM_SLOTS - 1)) ? '0 : r_slot + TAW'(1);
                        r_state <= S_SCAN_RD;
                    end else if (int'(r_lvl) + 1 >= MAX_DEPTH || r_parent == NO_STATE) begin
                        r_res   <= mk_res(KIND_STATUS, r_cur, r_prev, STAT_NOCHANGE);
                        r_ret   <= S_IDLE;
                        r_state <= S_EMIT;
                    end else begin
                        r_s     <= r_parent;
                        r_lvl   <= r_lvl + LW'(1);
                        r_state <= S_SRCH_RD;
                    end
                end
                S_FOUND: begin
                    r_lvl   <= '0;
                    r_state <= (r_leaf == NO_STATE) ? S_ERR_A : S_DESC_RD;
                end
                // follow entry substates down to a leaf
                S_DESC_RD: r_state <= S_DESC_CHK;
                S_DESC_CHK: begin
                    r_s <= r_cur;
                    r_d <= '0;
                    if (p_ent != NO_STATE) begin
                        r_leaf <= p_ent;
                        if (int'(r_lvl) + 1 < MAX_DEPTH) begin
                            r_lvl   <= r_lvl + LW'(1);
                            r_state <= S_DESC_RD;
                        end else begin
                            r_state <= S_CP_RD;
                        end
                    end else begin
                        r_state <= S_CP_RD;
                    end
                end
                // ancestor paths into scratch RAM
                S_CP_RD: r_state <= S_CP_CHK;
                S_CP_CHK: begin
                    if (p_par != NO_STATE && int'(r_d) + 1 < MAX_DEPTH) begin
                        r_d     <= r_d + LW'(1);
                        r_s     <= p_par;
                        r_state <= S_CP_RD;
                    end else begin
                        r_cd    <= r_d + LW'(1);
                        r_d     <= '0;
                        r_s     <= r_leaf;
                        r_state <= S_TP_RD;
                    end
                end
                S_TP_RD: r_state <= S_TP_CHK;
                S_TP_CHK: begin
                    if (p_par != NO_STATE && int'(r_d) + 1 < MAX_DEPTH) begin
                        r_d     <= r_d + LW'(1);
                        r_s     <= p_par;
                        r_state <= S_TP_RD;
                    end else begin
                        r_ci    <= r_cd;
                        r_tj    <= r_d + LW'(1);
                        r_state <= S_CMP_A;
                    end
                end
                // strip the shared outer part of both paths
                S_CMP_A: begin
                    if (r_ci == '0 || r_tj == '0) begin
                        r_pk    <= '0;
                        r_state <= S_EX_A;
                    end else begin
                        r_state <= S_CMP_B;
                    end
                end
                S_CMP_B: begin
                    r_c     <= p_q;
                    r_state <= S_CMP_C;
                end
                S_CMP_C: begin
                    if (r_c == p_q) begin
                        r_ci    <= r_ci - LW'(1);
                        r_tj    <= r_tj - LW'(1);
                        r_state <= S_CMP_A;
                    end else begin
                        r_pk    <= '0;
                        r_state <= S_EX_A;
                    end
                end
                // exit actions, innermost first
                S_EX_A: r_state <= (r_pk == r_ci) ? S_TR : S_EX_B;
                S_EX_B: begin
                    r_c     <= p_q;
                    r_state <= S_EX_C;
                end
                S_EX_C: begin
                    r_pk <= r_pk + LW'(1);
                    if (st_q.flags[1]) begin
                        r_res   <= mk_res(KIND_EXIT, r_c, NO_STATE, STAT_CHANGED);
                        r_ret   <= S_EX_A;
                        r_state <= S_EMIT;
                    end else begin
                        r_state <= S_EX_A;
                    end
                end
                S_TR: begin
                    r_pk <= r_tj;
                    if (r_act) begin
                        r_res   <= mk_res(KIND_TRANS, r_cur, r_leaf, STAT_CHANGED);
                        r_ret   <= S_EN_A;
                        r_state <= S_EMIT;
                    end else begin
                        r_state <= S_EN_A;
                    end
                end
                // entry actions, outermost first
                S_EN_A: r_state <= (r_pk == '0) ? S_ST_RD : S_EN_B;
                S_EN_B: begin
                    r_c     <= p_q;
                    r_state <= S_EN_C;
                end
                S_EN_C: begin
                    r_pk <= r_pk - LW'(1);
                    if (st_q.flags[0]) begin
                        r_res   <= mk_res(KIND_ENTRY, r_c, NO_STATE, STAT_CHANGED);
                        r_ret   <= S_EN_A;
                        r_state <= S_EMIT;
                    end else begin
                        r_state <= S_EN_A;
                    end
                end
                S_ST_RD: r_state <= S_ST_C;
                S_ST_C: begin
                    r_prev <= r_cur;
                    r_cur  <= r_leaf;
                    r_ret  <= S_IDLE;
                    if (r_leaf == r_cur) begin
                        r_res <= mk_res(KIND_STATUS, r_leaf, r_cur, STAT_SELF);
                    end else if (r_leaf == r_err) begin
                        r_res <= mk_res(KIND_STATUS, r_leaf, r_cur, STAT_ERROR);
                    end else if (st_q.count == 5'd0) begin
                        r_res <= mk_res(KIND_STATUS, r_leaf, r_cur, STAT_FINAL);
                    end else begin
                        r_res <= mk_res(KIND_STATUS, r_leaf, r_cur, STAT_CHANGED);
                    end
                    r_state <= S_EMIT;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_rsp.valid         = r_ov;
    assign o_rsp.kind          = r_out.kind;
    assign o_rsp.subject_state = r_out.subj;
    assign o_rsp.other_state   = r_out.oth;
    assign o_rsp.status        = r_out.stat;
    assign o_rsp.last          = r_out.last;

    hfde_ram #(.WIDTH($bits(t_st_ent)), .DEPTH(NUM_STATES)) u_st_ram (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (SAW'(i_req.index)),
        .i_wdata (st_wdata),
        .i_raddr (st_raddr),
        .o_rdata (st_q)
    );

    hfde_ram #(.WIDTH($bits(t_tr_ent)), .DEPTH(NUM_SLOTS)) u_tr_ram (
        .i_clk   (i_clk),
        .i_we    (tr_we),
        .i_waddr (TAW'(i_req.index)),
        .i_wdata (tr_wdata),
        .i_raddr (r_slot),
        .o_rdata (tr_q)
    );

    hfde_ram #(.WIDTH(7), .DEPTH(2 * MAX_DEPTH)) u_path_ram (
        .i_clk   (i_clk),
        .i_we    (p_we),
        .i_waddr (p_waddr),
        .i_wdata (r_s),
        .i_raddr (p_raddr),
        .o_rdata (p_q)
    );
endmodule

// ----- rtl/hfde_chk.sv -----
// ----------------------------------------------------------------------------
// hfde_chk
// Port-level checks of the dispatch engine, bound to the top level.
// ----------------------------------------------------------------------------
module hfde_chk
    import hfde_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [1:0] i_kind,
    input logic [6:0] i_subj,
    input logic [2:0] i_status,
    input logic       i_last
);
    a_rst_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result beat right after reset");

    a_last_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_last == (i_kind == KIND_STATUS)))
        else $error("last flag not tied to status beat");

    a_action_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_kind != KIND_STATUS |-> i_status == STAT_CHANGED)
        else $error("action beat with nonzero status");

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("second item taken while busy");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_kind) && $stable(i_subj)
        && $stable(i_last))
        else $error("stalled result beat changed");
endmodule

bind hierarchical_fsm_dispatch_engine hfde_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_kind      (o_rsp.kind),
    .i_subj      (o_rsp.subject_state),
    .i_status    (o_rsp.status),
    .i_last      (o_rsp.last)
);
